### hdl/ssa_pkg.sv
// types and constants shared by the segment sum accumulator
// no dependencies; compiled first
`default_nettype none

package ssa_pkg;

    // fixed field widths of the channels and registers
    localparam int SEG_W     = 10;
    localparam int COL_W     = 4;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int SEG_CNT_W = 11;
    localparam int ROW_CNT_W = 5;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [SEG_CNT_W-1:0] SEG_CNT_RESET = 11'd1024;
    localparam logic [ROW_CNT_W-1:0] ROW_CNT_RESET = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENT_COUNT = 1'b0,
        CFG_ROW_WIDTH     = 1'b1
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_SEG_RANGE = 2'd1,
        ST_COL_RANGE = 2'd2
    } t_status;

    // action codes
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // queue between classifier and execution unit
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } t_back_state;

endpackage

`default_nettype wire

### hdl/ssa_if.sv
// valid/ready channel interfaces for element input and result output
// depends on ssa_pkg for field widths
`default_nettype none

interface ssa_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic        [ssa_pkg::SEG_W-1:0]    segment;
    logic        [ssa_pkg::COL_W-1:0]    column;
    logic signed [ssa_pkg::VAL_W-1:0]    value;

    modport source (output valid, action, segment, column, value, input ready);
    modport sink   (input valid, action, segment, column, value, output ready);
endinterface

interface ssa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ssa_pkg::SUM_W-1:0]    sum;
    logic        [ssa_pkg::STATUS_W-1:0] status;

    modport source (output valid, sum, status, input ready);
    modport sink   (input valid, sum, status, output ready);
endinterface

`default_nettype wire

### hdl/segment_sum_accumulator_top.sv
// Segment sum accumulator. Each input transaction adds a signed value into
// table entry (segment, column) or reads that entry and clears it; exactly one
// result transaction comes back per input, in order. After reset the table is
// zeroed by a clearing pass over all MAX_SEGMENTS * MAX_ROW entries (16384 at the
// defaults) during which no input is accepted; configuration writes are taken
// throughout. Afterwards the execution unit handles each transaction by the
// registered memory read, then the add and write back of the single-port sum
// table, which waits until the result register can take the result. A 4-entry
// queue sits between the classifier and the execution unit, and the result
// register lets new input be taken while a result waits. Out-of-range segments
// or columns return status with sum 0 and leave the table untouched.
// depends on ssa_pkg, ssa_if, ssa_front, ssa_queue and ssa_back
`default_nettype none

module segment_sum_accumulator_top #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int MAX_ROW      = 16,
    parameter int DATA_WIDTH   = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire ssa_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [ssa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ssa_in_if.sink                              i_in,
    ssa_out_if.source                           o_res
);
    import ssa_pkg::*;

    localparam int DEPTH = MAX_SEGMENTS * MAX_ROW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = 1 + STATUS_W + AW + VAL_W;

    logic          push;
    logic          pop;
    logic          clearing;
    logic [QW-1:0] push_item;
    logic [QW-1:0] head_item;
    t_q_status     q_status;

    ssa_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_ROW      (MAX_ROW),
        .AW           (AW),
        .QW           (QW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_status (q_status),
        .i_clearing (clearing),
        .o_push     (push),
        .o_item     (push_item)
    );

    ssa_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_item),
        .i_pop    (pop),
        .o_data   (head_item),
        .o_status (q_status)
    );

    ssa_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH),
        .AW         (AW),
        .QW         (QW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (head_item),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

### hdl/ssa_front.sv
// front end: configuration registers, range checks and table address
// depends on ssa_pkg and ssa_in_if; feeds ssa_queue
`default_nettype none

module ssa_front #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int MAX_ROW      = 16,
    parameter int AW           = 14,
    parameter int QW           = 1 + ssa_pkg::STATUS_W + AW + ssa_pkg::VAL_W
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire ssa_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [ssa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ssa_in_if.sink                              i_in,
    input  wire ssa_pkg::t_q_status             i_q_status,
    input  wire logic                           i_clearing,
    output logic                                o_push,
    output logic [QW-1:0]                       o_item
);
    import ssa_pkg::*;

    logic [SEG_CNT_W-1:0] r_segment_count;
    logic [ROW_CNT_W-1:0] r_row_width;
    t_status              status;
    logic [AW-1:0]        addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_count <= SEG_CNT_RESET;
            r_row_width     <= ROW_CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEGMENT_COUNT: r_segment_count <= i_cfg_data[SEG_CNT_W-1:0];
                CFG_ROW_WIDTH:     r_row_width     <= i_cfg_data[ROW_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // a bad segment is reported before a bad column
    always_comb begin
        if (({1'b0, i_in.segment} >= r_segment_count) || (int'(i_in.segment) >= MAX_SEGMENTS))
            status = ST_SEG_RANGE;
        else if (({1'b0, i_in.column} >= r_row_width) || (int'(i_in.column) >= MAX_ROW))
            status = ST_COL_RANGE;
        else
            status = ST_OK;
    end

    // entry (s, c) lives at s * MAX_ROW + c regardless of row_width
    assign addr = AW'(int'(i_in.segment) * MAX_ROW + int'(i_in.column));

    assign i_in.ready = !i_clearing && !i_q_status.full;
    assign o_push     = i_in.valid && i_in.ready;
    assign o_item     = {i_in.action, status, addr, i_in.value};

endmodule

`default_nettype wire

### hdl/ssa_queue.sv
// small fifo of classified transactions between front and back end
// depends on ssa_pkg for depth and status struct
`default_nettype none

module ssa_queue #(
    parameter int WIDTH = 49
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [WIDTH-1:0]   i_data,
    input  wire logic               i_pop,
    output logic [WIDTH-1:0]        o_data,
    output ssa_pkg::t_q_status      o_status
);
    import ssa_pkg::*;

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    // depth is a power of two, pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)
                r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop)
                r_count <= r_count + 1'b1;
            else if (do_pop && !do_push)
                r_count <= r_count - 1'b1;
        end
    end

endmodule

`default_nettype wire

### hdl/ssa_back.sv
// back end: sum table memory, read-modify-write, clear pass and result register
// depends on ssa_pkg and ssa_out_if; drains ssa_queue
`default_nettype none

module ssa_back #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 16384,
    parameter int AW         = 14,
    parameter int QW         = 1 + ssa_pkg::STATUS_W + AW + ssa_pkg::VAL_W
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [QW-1:0]       i_q_data,
    input  wire ssa_pkg::t_q_status  i_q_status,
    output logic                     o_pop,
    output logic                     o_clearing,
    ssa_out_if.source                o_res
);
    import ssa_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] r_rd_data;

    t_back_state              r_state, n_state;
    logic [AW-1:0]            r_clr_addr, n_clr_addr;

    logic                     r_cur_action;
    t_status                  r_cur_status;
    logic [AW-1:0]            r_cur_addr;
    logic signed [VAL_W-1:0]  r_cur_value;

    logic                     r_out_valid;
    logic signed [SUM_W-1:0]  r_out_sum;
    t_status                  r_out_status;

    logic                     q_action;
    t_status                  q_status;
    logic [AW-1:0]            q_addr;
    logic signed [VAL_W-1:0]  q_value;

    logic                     rd_en;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_WIDTH-1:0] wr_data;
    logic signed [DATA_WIDTH-1:0] add_sum;
    logic signed [DATA_WIDTH-1:0] result;
    logic                     load_out;

    assign q_action = i_q_data[QW-1];
    assign q_status = t_status'(i_q_data[QW-2 -: STATUS_W]);
    assign q_addr   = i_q_data[VAL_W +: AW];
    assign q_value  = i_q_data[VAL_W-1:0];

    // value is sign-extended or truncated to the table width, sums wrap
    assign add_sum = r_rd_data + DATA_WIDTH'(r_cur_value);
    assign result  = (r_cur_status != ST_OK) ? '0 :
                     (r_cur_action == ACT_READ) ? r_rd_data : add_sum;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        o_pop      = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_cur_addr;
        wr_data    = '0;
        load_out   = 1'b0;
        unique case (r_state)
            BK_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                if (r_clr_addr == AW'(DEPTH - 1))
                    n_state = BK_IDLE;
                else
                    n_clr_addr = r_clr_addr + 1'b1;
            end
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                // write back only once the result register can take it
                if (!r_out_valid || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                    if (r_cur_status == ST_OK) begin
                        wr_en   = 1'b1;
                        wr_data = (r_cur_action == ACT_READ) ? '0 : add_sum;
                    end
                end
            end
            default: n_state = BK_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en)
            r_mem[wr_addr] <= wr_data;
        if (rd_en)
            r_rd_data <= r_mem[q_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (load_out)
                r_out_valid <= 1'b1;
            else if (o_res.ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur_action <= q_action;
            r_cur_status <= q_status;
            r_cur_addr   <= q_addr;
            r_cur_value  <= q_value;
        end
        if (load_out) begin
            r_out_sum    <= SUM_W'(result);
            r_out_status <= r_cur_status;
        end
    end

    assign o_clearing   = (r_state == BK_CLEAR);
    assign o_res.valid  = r_out_valid;
    assign o_res.sum    = r_out_sum;
    assign o_res.status = r_out_status;

endmodule

`default_nettype wire

### hdl/ssa_checker.sv
// port-level assertions for the segment sum accumulator, bound to the top level
// depends on ssa_pkg and segment_sum_accumulator_top
`default_nettype none

module ssa_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [ssa_pkg::SUM_W-1:0]    i_sum,
    input wire logic [ssa_pkg::STATUS_W-1:0] i_status
);
    import ssa_pkg::*;

    // transactions accepted but not yet answered: queue, execution slot, result register
    localparam int PEND_MAX = Q_DEPTH + 2;

    logic [3:0] r_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_pend <= '0;
        else if (in_acc && !out_acc)
            r_pend <= r_pend + 1'b1;
        else if (out_acc && !in_acc)
            r_pend <= r_pend - 1'b1;
    end

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pend != '0))
        else $error("result without an outstanding transaction");

    a_pending_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pend) <= PEND_MAX)
        else $error("more transactions in flight than the design can hold");

    a_flagged_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_OK)) |-> (i_sum == '0))
        else $error("flagged result carries a nonzero sum");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input accepted before the table clear");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_sum) && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind segment_sum_accumulator_top ssa_checker u_ssa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_sum       (o_res.sum),
    .i_status    (o_res.status)
);

`default_nettype wire
